/* rtl/hdr_weighted_radiance_merge_defines.svh */
// Assertion macros for the weighted radiance merge block.
// Included by the RTL modules that carry concurrent checks.
`ifndef HDR_WEIGHTED_RADIANCE_MERGE_DEFINES_SVH
`define HDR_WEIGHTED_RADIANCE_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
`define HWRM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HWRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HWRM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HWRM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/hwrm_pkg.sv */
// Shared constants and types of the weighted radiance merge block.
// No dependencies.
`default_nettype none
package hwrm_pkg;
   localparam int LEVELS    = 256;
   localparam int TBL_DEPTH = 256;
   localparam int ADDR_W    = 8;
   localparam int ENT_W     = 24;
   localparam int DVD_W     = 80;
   localparam int DSR_W     = 40;
   localparam int CNT_W     = 7;
   localparam logic [CNT_W-1:0] SAMPLE_STEPS = 7'd63;
   localparam logic [CNT_W-1:0] FINAL_STEPS  = 7'd47;
   localparam logic [15:0] LVL_CLAMP = 16'(LEVELS - 1);
   localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TBL_DEPTH - 1);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ENT_W-1:0]  weight;
      logic [ENT_W-1:0]  response;
   } tbl_wr_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] steps;
      logic [DSR_W-1:0] rem_init;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_ctl_type;
endpackage
`default_nettype wire

/* rtl/hdr_weighted_radiance_merge.sv */
// Top level of the weighted radiance merge: sequencer, accumulators, output register.
// Depends on hwrm_pkg, hwrm_tables, hwrm_div and the assertion macro header.
//
// channel | dir | handshake             | content
// req     | in  | req_tvalid/req_tready | table load or exposure sample
// rsp     | out | rsp_tvalid/rsp_tready | merged radiance of one pixel
// csr     | in  | csr_we                | exposure_sum register
//
// Table loads and skipped samples are taken in S_IDLE; a used sample runs the
// 63-step serial divider before the next request. A last sample may add the
// 47-step final division, plus a wait while the output register is still full.
// Reset is synchronous; the tables hold no reset value.
`default_nettype none
`include "hdr_weighted_radiance_merge_defines.svh"
module hdr_weighted_radiance_merge (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // table_index, response_entry, weight_entry, pixel_value, exposure_time, pad
   input  wire logic [111:0] req_tdata,
   // mode
   input  wire logic         req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // radiance, skipped_samples, pad
   output logic [39:0]       rsp_tdata,
   // no_weight
   output logic              rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata
);
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_MULA   = 10'b0000000010,
      S_MULB   = 10'b0000000100,
      S_DSTART = 10'b0000001000,
      S_DWAIT  = 10'b0000010000,
      S_ACC    = 10'b0000100000,
      S_FIN    = 10'b0001000000,
      S_FWAIT  = 10'b0010000000,
      S_FRES   = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] es_ff;
   logic [31:0] et_ff, et_in;
   logic        last_ff, last_in;
   logic signed [47:0] wr_ff, wr_in;
   logic signed [23:0] w_ff, w_in;
   logic [62:0] mag_ff, mag_in;
   logic        pneg_ff, pneg_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [39:0] wt_ff, wt_in;
   logic [3:0]  skip_ff, skip_in;
   logic        fneg_ff, fneg_in;
   logic [31:0] rad_ff, rad_in;
   logic        nw_ff, nw_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_rad_ff, rsp_rad_in;
   logic        rsp_nw_ff, rsp_nw_in;
   logic [3:0]  rsp_skip_ff, rsp_skip_in;

   logic accept, rsp_free;
   logic signed [17:0] pix;
   logic [17:0] pix_abs;
   logic [31:0] lvl_mag;
   logic [15:0] lvl, lvl_c;
   logic        skip;
   logic [hwrm_pkg::ADDR_W-1:0] rd_addr;
   hwrm_pkg::tbl_wr_type  tbl_wr;
   hwrm_pkg::div_ctl_type div_ctl;
   logic signed [23:0] tbl_w, tbl_r;
   logic div_busy, div_done;
   logic [hwrm_pkg::DVD_W-1:0] div_q;
   logic signed [47:0] wr_adj;
   logic signed [31:0] prod;
   logic [30:0] prod_abs;
   logic [63:0] term;
   logic [64:0] sum_x;
   logic [40:0] wt_x;
   logic [63:0] fa;
   logic [39:0] fb;
   logic [47:0] fq;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      pix     = req_tdata[73:56];
      pix_abs = pix[17] ? 18'(-pix) : 18'(pix);
      lvl_mag = 32'(pix_abs) * 32'(hwrm_pkg::LEVELS) + 32'd32768;
      lvl     = lvl_mag[31:16];
      skip    = pix[17] && (lvl != 16'd0);
      lvl_c   = (lvl >= 16'(hwrm_pkg::LEVELS)) ? hwrm_pkg::LVL_CLAMP : lvl;
      rd_addr = (lvl_c > 16'(hwrm_pkg::ADDR_MAX)) ? hwrm_pkg::ADDR_MAX
                                                  : lvl_c[hwrm_pkg::ADDR_W-1:0];
      tbl_wr.en       = accept && !req_tuser;
      tbl_wr.addr     = req_tdata[7:0];
      tbl_wr.response = req_tdata[31:8];
      tbl_wr.weight   = req_tdata[55:32];
   end

   hwrm_tables u_tables (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_en    (accept && req_tuser),
      .rd_addr  (rd_addr),
      .weight   (tbl_w),
      .response (tbl_r)
   );

   always_comb begin
      wr_adj   = wr_ff + (wr_ff[47] ? 48'sd65535 : 48'sd0);
      prod     = wr_adj[47:16];
      prod_abs = prod[31] ? 31'(-prod) : prod[30:0];
      term     = pneg_ff ? -{1'b0, div_q[62:0]} : {1'b0, div_q[62:0]};
      sum_x    = {sum_ff[63], sum_ff} + {term[63], term};
      wt_x     = {wt_ff[39], wt_ff} + {{17{w_ff[23]}}, w_ff};
      fa       = sum_ff[63] ? -sum_ff : sum_ff;
      fb       = wt_ff[39] ? -wt_ff : wt_ff;
      fq       = {1'b0, div_q[46:0]};
      div_ctl  = '0;
      if (state_ff == S_DSTART) begin
         div_ctl.start    = 1'b1;
         div_ctl.steps    = hwrm_pkg::SAMPLE_STEPS;
         div_ctl.dividend = {mag_ff, 17'd0};
         div_ctl.divisor  = (et_ff == 32'd0) ? 40'd1 : {8'd0, et_ff};
      end else if ((state_ff == S_FIN) && (wt_ff != '0) && ({7'd0, fa[63:31]} < fb)) begin
         div_ctl.start    = 1'b1;
         div_ctl.steps    = hwrm_pkg::FINAL_STEPS;
         div_ctl.rem_init = {7'd0, fa[63:31]};
         div_ctl.dividend = {fa[30:0], 16'd0, 33'd0};
         div_ctl.divisor  = fb;
      end
   end

   hwrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in      = state_ff;
      et_in         = et_ff;
      last_in       = last_ff;
      wr_in         = wr_ff;
      w_in          = w_ff;
      mag_in        = mag_ff;
      pneg_in       = pneg_ff;
      sum_in        = sum_ff;
      wt_in         = wt_ff;
      skip_in       = skip_ff;
      fneg_in       = fneg_ff;
      rad_in        = rad_ff;
      nw_in         = nw_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_rad_in    = rsp_rad_ff;
      rsp_nw_in     = rsp_nw_ff;
      rsp_skip_in   = rsp_skip_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser) begin
               et_in   = req_tdata[105:74];
               last_in = req_tlast;
               if (skip) begin
                  if (skip_ff != 4'hF) begin
                     skip_in = skip_ff + 4'd1;
                  end
                  state_in = req_tlast ? S_FIN : S_IDLE;
               end else begin
                  state_in = S_MULA;
               end
            end
         end
         S_MULA: begin
            wr_in    = 48'(tbl_w) * 48'(tbl_r);
            w_in     = tbl_w;
            state_in = S_MULB;
         end
         S_MULB: begin
            mag_in   = 63'(prod_abs) * 63'(es_ff);
            pneg_in  = prod[31];
            state_in = S_DSTART;
         end
         S_DSTART: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (sum_x[64] != sum_x[63]) begin
               sum_in = sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               sum_in = sum_x[63:0];
            end
            if (wt_x[40] != wt_x[39]) begin
               wt_in = wt_x[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
            end else begin
               wt_in = wt_x[39:0];
            end
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            fneg_in = sum_ff[63] ^ wt_ff[39];
            nw_in   = (wt_ff == '0);
            if (wt_ff == '0) begin
               rad_in   = 32'd0;
               state_in = S_OUT;
            end else if ({7'd0, fa[63:31]} >= fb) begin
               rad_in   = (sum_ff[63] ^ wt_ff[39]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               state_in = S_OUT;
            end else begin
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            if (div_done) begin
               state_in = S_FRES;
            end
         end
         S_FRES: begin
            if (fneg_ff) begin
               rad_in = (fq > 48'h8000_0000) ? 32'h8000_0000 : 32'(-fq);
            end else begin
               rad_in = (fq > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : fq[31:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_rad_in    = rad_ff;
               rsp_nw_in     = nw_ff;
               rsp_skip_in   = skip_ff;
               sum_in        = '0;
               wt_in         = '0;
               skip_in       = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         es_ff         <= 32'd1;
         sum_ff        <= '0;
         wt_ff         <= '0;
         skip_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            es_ff <= csr_wdata;
         end
         sum_ff        <= sum_in;
         wt_ff         <= wt_in;
         skip_ff       <= skip_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      et_ff       <= et_in;
      last_ff     <= last_in;
      wr_ff       <= wr_in;
      w_ff        <= w_in;
      mag_ff      <= mag_in;
      pneg_ff     <= pneg_in;
      fneg_ff     <= fneg_in;
      rad_ff      <= rad_in;
      nw_ff       <= nw_in;
      rsp_rad_ff  <= rsp_rad_in;
      rsp_nw_ff   <= rsp_nw_in;
      rsp_skip_ff <= rsp_skip_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_skip_ff, rsp_rad_ff};
   assign rsp_tuser  = rsp_nw_ff;

   `HWRM_ASSERT_NOW(a_div_owner, clock, reset, div_busy, (state_ff == S_DWAIT) || (state_ff == S_FWAIT))
   `HWRM_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff == S_OUT))
   `HWRM_ASSERT_NEXT(a_acc_clear, clock, reset, (state_ff == S_OUT) && rsp_free, (wt_ff == '0) && (skip_ff == '0) && (sum_ff == '0))
endmodule
`default_nettype wire

/* rtl/hwrm_tables.sv */
// Response and weight table memory, one write and one registered read port.
// Depends on hwrm_pkg.
`default_nettype none
module hwrm_tables (
   input  wire logic                              clock,
   input  wire hwrm_pkg::tbl_wr_type              wr,
   input  wire logic                              rd_en,
   input  wire logic [hwrm_pkg::ADDR_W-1:0]       rd_addr,
   output logic signed [hwrm_pkg::ENT_W-1:0]      weight,
   output logic signed [hwrm_pkg::ENT_W-1:0]      response
);
   logic [2*hwrm_pkg::ENT_W-1:0] mem [hwrm_pkg::TBL_DEPTH];
   logic [2*hwrm_pkg::ENT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= {wr.weight, wr.response};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign weight   = rdata_ff[2*hwrm_pkg::ENT_W-1:hwrm_pkg::ENT_W];
   assign response = rdata_ff[hwrm_pkg::ENT_W-1:0];
endmodule
`default_nettype wire

/* rtl/hwrm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on hwrm_pkg.
`default_nettype none
module hwrm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hwrm_pkg::div_ctl_type         ctl,
   output logic                               busy,
   output logic                               done,
   output logic [hwrm_pkg::DVD_W-1:0]         quotient
);
   logic [hwrm_pkg::DSR_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [hwrm_pkg::DVD_W-1:0] sh_ff, sh_in;
   logic [hwrm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [hwrm_pkg::DSR_W:0]   rem_sh, rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, sh_ff[hwrm_pkg::DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         rem_in  = ctl.rem_init;
         sh_in   = ctl.dividend;
         cnt_in  = ctl.steps;
         dsr_in  = ctl.divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub[hwrm_pkg::DSR_W-1:0];
            sh_in  = {sh_ff[hwrm_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[hwrm_pkg::DSR_W-1:0];
            sh_in  = {sh_ff[hwrm_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hwrm_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = busy_ff && (cnt_ff == hwrm_pkg::CNT_W'(1));
   assign quotient = sh_ff;
endmodule
`default_nettype wire
